@@ hw/rtl/stdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Square tone decay generator package
// Shared types and constants for the controller, the datapath and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package stdg_pkg;

   localparam int FREQ_W  = 20;
   localparam int DUR_W   = 16;
   localparam int AMP_W   = 16;
   localparam int RATE_W  = 16;
   localparam int PEAK_W  = 15;
   localparam int LEN_W   = 22;
   localparam int HALF_W  = 19;
   localparam int SMP_W   = 16;
   localparam int DEN_W   = 25;   // 5 * note length
   localparam int QUO_W   = 32;   // divider dividend / quotient shift register
   localparam int CNT_W   = 6;
   localparam int RECIP_W = 29;   // width of the 1/1000 reciprocal
   localparam int LEN_SHIFT = 38;
   localparam int LQ_W    = 23;   // rate * duration / 1000 before saturation

   localparam logic [LEN_W-1:0]  LEN_MAX     = 22'h3F_FFFF;
   localparam logic [PEAK_W-1:0] AMP_MAX     = 15'h7FFF;
   localparam logic [RATE_W-1:0] RATE_RESET  = 16'd16000;

   // For every 32-bit x, floor(x / 1000) equals (x * LEN_RECIP) >> LEN_SHIFT.
   localparam logic [RECIP_W-1:0] LEN_RECIP  = 29'd274877907;

   // Divider step counts for each kind of division.
   localparam logic [CNT_W-1:0]  HALF_STEPS  = 6'd19;
   localparam logic [CNT_W-1:0]  TICK_STEPS  = 6'd15;

   // Register index of the output rate on the configuration port.
   localparam logic REG_RATE = 1'b0;

   // Request kinds carried in the mode field.
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LEN_SETUP,
      ST_LEN_SCALE,
      ST_HALF_SETUP,
      ST_HALF_DIV,
      ST_TICK_PREP,
      ST_TICK_MUL,
      ST_TICK_DIV,
      ST_TICK_OUT
   } state_type;

   typedef struct packed {
      logic capture;       // latch the request fields
      logic len_load;      // hold rate * duration for the length scale
      logic half_load;     // load divider with rate * 8 / frequency
      logic tick_load;     // load divider with peak * num / den
      logic div_step;      // one restoring divide step
      logic len_save;      // scale by 1/1000 and store the note length
      logic note_start;    // store the half period and arm the note
      logic tick_prep;     // form numerator and denominator of the decay
      logic emit;          // hand the result to the output register
   } cmd_type;

   typedef struct packed {
      logic mode_start;    // captured item is a start
      logic start_ok;      // start operands are all nonzero
      logic active;        // a note is playing
      logic div_done;      // divider has no steps left
   } status_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    playing;
      logic                    last;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/square_tone_decay_generator.sv @@
// ----------------------------------------------------------------------------
// Square tone decay generator
// Square-wave tone with a linear decay envelope, one sample per tick.
// ----------------------------------------------------------------------------
// A playing tick forms the decay operands and runs the 15-step divide
// before its sample is emitted; an idle tick goes straight to the output.
// Items are taken one at a time; a tick waits until the output register
// is free. A start scales the length, then runs the 19-step half-period
// divide; an ignored start returns to idle. Reset is synchronous, active
// high; it silences the generator and sets the rate register to 16000.
`default_nettype none

module square_tone_decay_generator (
   input  wire          clock,
   input  wire          reset,
   // Request channel.
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [55:0]  req_tdata,   // freq_q4[19:0], note_ms[35:20],
                                     // amplitude[51:36], zero fill [55:52]
   input  wire          req_tuser,   // mode: 0 = sample tick, 1 = start note
   // Response channel.
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [15:0]  rsp_tdata,   // sample[15:0], signed
   output logic         rsp_tuser,   // playing
   output logic         rsp_tlast,   // last sample of the note
   // Configuration port.
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import stdg_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;
   logic       ctrl_idle;
   logic       accept;
   logic       out_free;
   logic       csr_write;

   logic [RATE_W-1:0] rate_ff;

   logic              rsp_valid_ff;
   logic [SMP_W-1:0]  rsp_data_ff;
   logic              rsp_user_ff;
   logic              rsp_last_ff;

   // The register index sits in paddr[2]; the low byte-lane bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_write && csr_paddr[2] == REG_RATE) begin
         rate_ff <= csr_pwdata[RATE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_RATE) begin
         csr_prdata = {{(32-RATE_W){1'b0}}, rate_ff};
      end
   end

   // A new transaction is taken whenever the controller is idle, even while
   // the previous sample still waits in the output register.
   assign req_tready = ctrl_idle;
   assign accept     = req_tvalid && req_tready;

   // The output register can take a sample when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;

   stdg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_free (out_free),
      .status   (status),
      .cmd      (cmd),
      .idle     (ctrl_idle)
   );

   stdg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_mode    (req_tuser),
      .req_freq    (req_tdata[19:0]),
      .req_dur     (req_tdata[35:20]),
      .req_amp     (req_tdata[51:36]),
      .rate        (rate_ff),
      .status      (status),
      .result      (result)
   );

   // Output register: holds one finished sample until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= result.sample;
         rsp_user_ff <= result.playing;
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A new sample must never overwrite one the consumer has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("sample emitted into an occupied output register");

   // Silence outside a note: an idle sample is zero and never marked last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("idle sample is not silent");

   // The final sample of a note leaves the generator idle.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && result.last) |=> !status.active)
      else $error("note still active after its last sample");

   // No new transaction is taken while the divider is still working.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> status.div_done)
      else $error("transaction accepted during a division");

endmodule

`default_nettype wire

@@ hw/rtl/stdg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Square tone decay generator controller
// Sequences the start and tick work over the datapath's shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module stdg_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire                     out_free,
   input  stdg_pkg::status_type    status,
   output stdg_pkg::cmd_type       cmd,
   output logic                    idle
);
   import stdg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.mode_start) begin
               state_in = status.start_ok ? ST_LEN_SETUP : ST_IDLE;
            end else begin
               state_in = status.active ? ST_TICK_PREP : ST_TICK_OUT;
            end
         end
         ST_LEN_SETUP:  state_in = ST_LEN_SCALE;
         ST_LEN_SCALE:  state_in = ST_HALF_SETUP;
         ST_HALF_SETUP: state_in = ST_HALF_DIV;
         ST_HALF_DIV: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         ST_TICK_PREP:  state_in = ST_TICK_MUL;
         ST_TICK_MUL:   state_in = ST_TICK_DIV;
         ST_TICK_DIV: begin
            if (status.div_done) state_in = ST_TICK_OUT;
         end
         ST_TICK_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle        = 1'b1;
            cmd.capture = accept;
         end
         ST_LEN_SETUP:  cmd.len_load = 1'b1;
         ST_LEN_SCALE:  cmd.len_save = 1'b1;
         ST_HALF_SETUP: cmd.half_load = 1'b1;
         ST_HALF_DIV: begin
            cmd.div_step   = !status.div_done;
            cmd.note_start = status.div_done;
         end
         ST_TICK_PREP:  cmd.tick_prep = 1'b1;
         ST_TICK_MUL:   cmd.tick_load = 1'b1;
         ST_TICK_DIV:   cmd.div_step  = !status.div_done;
         ST_TICK_OUT:   cmd.emit      = out_free;
         default:       cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/stdg_datapath.sv @@
// ----------------------------------------------------------------------------
// Square tone decay generator datapath
// Note state, decay arithmetic, a reciprocal scale for the note length and a
// shared bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module stdg_datapath (
   input  wire                          clock,
   input  wire                          reset,
   input  stdg_pkg::cmd_type            cmd,
   input  wire                          req_mode,
   input  wire [stdg_pkg::FREQ_W-1:0]   req_freq,
   input  wire [stdg_pkg::DUR_W-1:0]    req_dur,
   input  wire [stdg_pkg::AMP_W-1:0]    req_amp,
   input  wire [stdg_pkg::RATE_W-1:0]   rate,
   output stdg_pkg::status_type         status,
   output stdg_pkg::result_type         result
);
   import stdg_pkg::*;

   // Captured request.
   logic              mode_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [AMP_W-1:0]  amp_ff;

   // Note state.
   logic              active_ff, active_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic [HALF_W-1:0] phase_ff, phase_in;
   logic              pol_ff, pol_in;
   logic [PEAK_W-1:0] peak_ff, peak_in;

   // Decay operands.
   logic [DEN_W-1:0]  num_ff, den_ff;

   // Divider.
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [DEN_W:0]            trial;
   logic [DEN_W:0]            diff;
   logic                      fits;
   logic [2*DUR_W-1:0]        rate_dur;
   logic [QUO_W+RECIP_W-1:0]  len_prod;
   logic [LQ_W-1:0]           len_quo;
   logic [PEAK_W+DEN_W-1:0]   prod;
   logic [DEN_W-1:0]          den_calc, three_n;
   logic [LEN_W:0]            idx_inc;
   logic [HALF_W:0]           phase_inc;
   logic                      fin;
   logic [PEAK_W-1:0]         mag;
   logic [SMP_W-1:0]          mag_ext;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         freq_ff <= req_freq;
         dur_ff  <= req_dur;
         amp_ff  <= req_amp;
      end
   end

   always_comb begin
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = trial >= {1'b0, dvs_ff};
      rate_dur = rate * dur_ff;
      // The held product rate * duration is divided by 1000 through its
      // reciprocal.
      len_prod = quo_ff * LEN_RECIP;
      len_quo  = len_prod[LEN_SHIFT+LQ_W-1:LEN_SHIFT];
      prod     = peak_ff * num_ff;
      den_calc = {1'b0, len_ff, 2'b00} + {3'b000, len_ff};
      three_n  = {2'b00, idx_ff, 1'b0} + {3'b000, idx_ff};
      idx_inc  = {1'b0, idx_ff} + {{LEN_W{1'b0}}, 1'b1};
      phase_inc = {1'b0, phase_ff} + {{HALF_W{1'b0}}, 1'b1};
      fin      = idx_inc >= {1'b0, len_ff};
      mag      = quo_ff[PEAK_W-1:0];
      mag_ext  = {1'b0, mag};
   end

   // Divider: one quotient bit per step, shifted into the low end of quo_ff.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      if (cmd.len_load) begin
         quo_in = rate_dur;
      end else if (cmd.half_load) begin
         rem_in = '0;
         quo_in = {rate, 3'b000, {(QUO_W-RATE_W-3){1'b0}}};
         dvs_in = {{(DEN_W-FREQ_W){1'b0}}, freq_ff};
         cnt_in = HALF_STEPS;
      end else if (cmd.tick_load) begin
         // The quotient never exceeds the peak, so only its low bits are run.
         rem_in = prod[PEAK_W+DEN_W-1:PEAK_W];
         quo_in = {prod[PEAK_W-1:0], {(QUO_W-PEAK_W){1'b0}}};
         dvs_in = den_ff;
         cnt_in = TICK_STEPS;
      end else if (cmd.div_step && cnt_ff != '0) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_prep) begin
         den_ff <= den_calc;
         num_ff <= den_calc - three_n;
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      half_in   = half_ff;
      phase_in  = phase_ff;
      pol_in    = pol_ff;
      peak_in   = peak_ff;
      if (cmd.len_save) begin
         if (len_quo > {1'b0, LEN_MAX}) begin
            len_in = LEN_MAX;
         end else if (len_quo == '0) begin
            len_in = {{(LEN_W-1){1'b0}}, 1'b1};
         end else begin
            len_in = len_quo[LEN_W-1:0];
         end
      end
      if (cmd.note_start) begin
         half_in   = (quo_ff[HALF_W-1:0] == '0) ? {{(HALF_W-1){1'b0}}, 1'b1}
                                                : quo_ff[HALF_W-1:0];
         peak_in   = (amp_ff > {1'b0, AMP_MAX}) ? AMP_MAX : amp_ff[PEAK_W-1:0];
         active_in = 1'b1;
         idx_in    = '0;
         phase_in  = '0;
         pol_in    = 1'b0;
      end
      if (cmd.emit && active_ff) begin
         if (phase_inc >= {1'b0, half_ff}) begin
            phase_in = '0;
            pol_in   = !pol_ff;
         end else begin
            phase_in = phase_inc[HALF_W-1:0];
         end
         if (fin) begin
            active_in = 1'b0;
            idx_in    = '0;
         end else begin
            idx_in = idx_inc[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         half_ff   <= '0;
         phase_ff  <= '0;
         pol_ff    <= 1'b0;
         peak_ff   <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         half_ff   <= half_in;
         phase_ff  <= phase_in;
         pol_ff    <= pol_in;
         peak_ff   <= peak_in;
      end
   end

   always_comb begin
      status.mode_start = (mode_ff == MODE_START);
      status.start_ok   = (freq_ff != '0) && (dur_ff != '0) && (amp_ff != '0);
      status.active     = active_ff;
      status.div_done   = (cnt_ff == '0);
      if (active_ff) begin
         result.sample  = pol_ff ? -$signed(mag_ext) : $signed(mag_ext);
         result.playing = 1'b1;
         result.last    = fin;
      end else begin
         result.sample  = '0;
         result.playing = 1'b0;
         result.last    = 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square tone decay generator testbench
// Drives start and tick transactions into the generator over the request
// stream, predicts every sample with a scoreboard of its own, and compares
// each response field by field. A few directed notes cover the corner cases,
// then random phases run at several sample rates, all but the first with random back pressure.
// ----------------------------------------------------------------------------
module tb;
   import stdg_pkg::*;

   localparam logic [2:0] RATE_ADDR     = {REG_RATE, 2'b00};
   localparam logic [2:0] SPARE_ADDR    = {~REG_RATE, 2'b00};
   // Wait used by drain, long enough for a start to finish.
   localparam int         SETTLE_CYCLES = 80;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         PHASE_ITEMS   = 240;

   // Scoreboard: a copy of the note state, the rate register, and the queue
   // of samples that the accepted ticks are owed.
   class tone_scoreboard;
      logic [RATE_W-1:0] rate;
      logic              note_on;
      logic [LEN_W-1:0]  index;
      logic [LEN_W-1:0]  length;
      logic [HALF_W-1:0] half;
      logic [HALF_W-1:0] phase;
      logic              negative;
      logic [PEAK_W-1:0] peak;
      result_type        expected_samples[$];
      int                error_count;

      function new();
         rate        = RATE_RESET;
         note_on     = 1'b0;
         index       = '0;
         length      = '0;
         half        = '0;
         phase       = '0;
         negative    = 1'b0;
         peak        = '0;
         error_count = 0;
      endfunction

      function void write_register(logic [2:0] addr, logic [31:0] value);
         if (addr == RATE_ADDR) rate = value[RATE_W-1:0];
      endfunction

      function void note_request(logic mode, logic [FREQ_W-1:0] freq,
                                 logic [DUR_W-1:0] dur, logic [AMP_W-1:0] amp);
         logic [63:0]     len;
         logic [31:0]     hp;
         logic [63:0]     den;
         logic [63:0]     num;
         logic [SMP_W-1:0] mag;
         result_type      r;
         if (mode == MODE_START) begin
            // A start with any zero operand leaves the note alone.
            if (freq == 0 || dur == 0 || amp == 0) return;
            len = (64'(rate) * 64'(dur)) / 64'd1000;
            if (len == 0) len = 1;
            if (len > 64'(LEN_MAX)) len = 64'(LEN_MAX);
            hp = (32'(rate) * 32'd8) / 32'(freq);
            if (hp == 0) hp = 1;
            note_on  = 1'b1;
            index    = '0;
            length   = len[LEN_W-1:0];
            half     = hp[HALF_W-1:0];
            phase    = '0;
            negative = 1'b0;
            peak     = (amp > AMP_MAX) ? AMP_MAX : amp[PEAK_W-1:0];
            return;
         end
         if (!note_on) begin
            r = '0;
            expected_samples.push_back(r);
            return;
         end
         den = 64'(length) * 64'd5;
         num = den - 64'(index) * 64'd3;
         mag = SMP_W'((64'(peak) * num) / den);
         r.sample  = negative ? (16'd0 - mag) : mag;
         r.playing = 1'b1;
         r.last    = (64'(index) + 1 >= 64'(length));
         expected_samples.push_back(r);
         phase = phase + 1'b1;
         if (phase >= half) begin
            phase    = '0;
            negative = ~negative;
         end
         if (r.last) begin
            note_on = 1'b0;
            index   = '0;
         end else begin
            index = index + 1'b1;
         end
      endfunction

      function void check_response(logic signed [SMP_W-1:0] got_sample,
                                   logic got_playing, logic got_last);
         result_type e;
         if (expected_samples.size() == 0) begin
            $error("sample %0d arrived with no tick waiting for it", got_sample);
            error_count++;
            return;
         end
         e = expected_samples.pop_front();
         if (e.sample !== got_sample) begin
            $error("sample: expected %0d, actual %0d", e.sample, got_sample);
            error_count++;
         end
         if (e.playing !== got_playing) begin
            $error("playing: expected %0b, actual %0b", e.playing, got_playing);
            error_count++;
         end
         if (e.last !== got_last) begin
            $error("last: expected %0b, actual %0b", e.last, got_last);
            error_count++;
         end
      endfunction
   endclass

   tone_scoreboard tones = new();

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [55:0]  req_tdata;    // freq_q4, note length in ms, amplitude, fill
   logic         req_tuser;    // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;    // sample
   logic         rsp_tuser;    // playing
   logic         rsp_tlast;    // last
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Random idling on both sides is switched off for one whole phase.
   bit           gaps_on = 1'b1;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit           hold_request = 1'b0;

   square_tone_decay_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: checks every response transaction and drives rsp_tready.
   // The long hold-off is counted here, so the sender keeps offering ticks
   // while the block backs up and stops taking them.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tones.check_response($signed(rsp_tdata), rsp_tuser, rsp_tlast);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(0, 99) < 26);
         end
      end
   end

   // Offers one request transaction and returns at the edge that takes it.
   // tvalid is only lowered for a gap, so back-to-back items keep it high.
   task automatic send_item(input logic mode, input logic [FREQ_W-1:0] freq,
                            input logic [DUR_W-1:0] dur,
                            input logic [AMP_W-1:0] amp);
      while (gaps_on && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, amp, dur, freq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tones.note_request(mode, freq, dur, amp);
   endtask

   task automatic send_start(input logic [FREQ_W-1:0] freq,
                             input logic [DUR_W-1:0] dur,
                             input logic [AMP_W-1:0] amp);
      send_item(MODE_START, freq, dur, amp);
   endtask

   // The start-only fields carry random junk on ticks; the block must
   // ignore them.
   task automatic send_tick();
      send_item(MODE_TICK, FREQ_W'($urandom()), DUR_W'($urandom()),
                AMP_W'($urandom()));
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      tones.write_register(addr, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every owed sample has come back, then lets a start that
   // gives no sample finish before the register is touched again.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tones.expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly whole notes: a short start followed by enough ticks to reach the
   // last sample and a little silence. The rest are arbitrary starts (zero
   // operands, long notes, replacements mid-note) and loose runs of ticks.
   task automatic random_phase(input int n_items);
      int                sent;
      int                pick;
      int                k;
      int                ticks;
      logic [63:0]       len;
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
      logic [AMP_W-1:0]  amp;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            dur  = DUR_W'($urandom_range(1, (tones.rate > 20000) ? 1 : 3));
            k    = $urandom_range(1, 12);
            freq = FREQ_W'((32'(tones.rate) * 8) / k);
            if (freq == 0 || $urandom_range(0, 3) == 0)
               freq = FREQ_W'($urandom_range(1, 20'hFFFFF));
            amp  = AMP_W'($urandom_range(1, 16'hFFFF));
            send_start(freq, dur, amp);
            sent++;
            len = (64'(tones.rate) * 64'(dur)) / 64'd1000;
            if (len == 0) len = 1;
            ticks = int'(len) + $urandom_range(0, 2);
            repeat (ticks) begin
               send_tick();
               sent++;
            end
         end else if (pick < 90) begin
            freq = ($urandom_range(0, 5) == 0) ? '0 : FREQ_W'($urandom());
            dur  = ($urandom_range(0, 5) == 0) ? '0 : DUR_W'($urandom());
            amp  = ($urandom_range(0, 5) == 0) ? '0 : AMP_W'($urandom());
            send_start(freq, dur, amp);
            if (freq != 0 && dur != 0 && amp != 0) sent++;
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_tick();
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tuser   <= MODE_TICK;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // A write to an address past the register list must change nothing.
      csr_write(SPARE_ADDR, 32'h0000_1F40);

      // Reset rate. Idle ticks, starts with each operand zero, a clamped
      // amplitude with a two-sample half period, a note replaced mid-way by
      // one whose half period rounds down to zero, and an ignored start that
      // must not disturb the note in progress.
      send_tick();
      send_start(20'd100, 16'd5, 16'd0);
      send_start(20'd0, 16'd5, 16'd100);
      send_start(20'd100, 16'd0, 16'd100);
      send_tick();
      send_start(20'd64000, 16'd1, 16'hFFFF);
      repeat (3) send_tick();
      send_start(20'hFFFFF, 16'd1, 16'd3);
      send_start(20'd5, 16'd1, 16'd0);
      repeat (3) send_tick();
      drain();

      // A zero rate gives one-sample notes, so the last flag shows at once.
      // The note above is still playing when the rate changes and is then
      // replaced by the new start.
      csr_write(RATE_ADDR, 32'd0);
      send_start(20'hFFFFF, 16'hFFFF, 16'h7FFF);
      repeat (2) send_tick();
      drain();

      // Full-scale rate and duration: the length saturates and the half
      // period takes its widest value. Upper data bits must be dropped.
      csr_write(RATE_ADDR, 32'hFFFF_FFFF);
      send_start(20'd1, 16'hFFFF, 16'h7FFF);
      repeat (2) send_tick();
      drain();

      // Random phases. The long note from above carries into the first one,
      // so a rate change in the middle of a note is covered as well.
      gaps_on = 1'b0;
      csr_write(RATE_ADDR, 32'd8000);
      random_phase(PHASE_ITEMS);
      drain();
      gaps_on = 1'b1;

      csr_write(RATE_ADDR, 32'd48000);
      hold_request = 1'b1;
      random_phase(PHASE_ITEMS);
      drain();

      csr_write(RATE_ADDR, 32'd44100);
      random_phase(PHASE_ITEMS);
      drain();

      csr_write(RATE_ADDR, 32'd0);
      random_phase(PHASE_ITEMS);
      drain();

      csr_write(RATE_ADDR, 32'd65535);
      random_phase(PHASE_ITEMS);
      drain();

      csr_write(RATE_ADDR, $urandom());
      random_phase(PHASE_ITEMS);
      drain();

      if (tones.error_count == 0 && tones.expected_samples.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Far beyond the slowest correct run, hold-off and idling included.
   initial begin
      #10ms;
      $display("tb: errors");
      $finish;
   end

endmodule
